// ===== sv/arsp_pkg.sv =====
// ============================================================================
// arsp_pkg
// Shared types and constants of the access-rights string parser.
// ============================================================================
package arsp_pkg;

    localparam int MASK_W = 15;

    // Parser phase codes.
    localparam logic [3:0] PH_TOP   = 4'd0;
    localparam logic [3:0] PH_FSEEN = 4'd1;
    localparam logic [3:0] PH_FOPEN = 4'd2;
    localparam logic [3:0] PH_FSTAR = 4'd3;
    localparam logic [3:0] PH_FGRP  = 4'd4;
    localparam logic [3:0] PH_DSEEN = 4'd5;
    localparam logic [3:0] PH_DOPEN = 4'd6;
    localparam logic [3:0] PH_DSTAR = 4'd7;
    localparam logic [3:0] PH_DGRP  = 4'd8;
    localparam logic [3:0] PH_CSEEN = 4'd9;
    localparam logic [3:0] PH_COPEN = 4'd10;
    localparam logic [3:0] PH_CSTAR = 4'd11;
    localparam logic [3:0] PH_CGRP  = 4'd12;

    // Permission bits.
    localparam logic [MASK_W-1:0] B_EXEC   = 15'h0001;
    localparam logic [MASK_W-1:0] B_WFILE  = 15'h0002;
    localparam logic [MASK_W-1:0] B_RFILE  = 15'h0004;
    localparam logic [MASK_W-1:0] B_RDIR   = 15'h0008;
    localparam logic [MASK_W-1:0] B_RMDIR  = 15'h0010;
    localparam logic [MASK_W-1:0] B_RMFILE = 15'h0020;
    localparam logic [MASK_W-1:0] B_MKCHR  = 15'h0040;
    localparam logic [MASK_W-1:0] B_MKDIR  = 15'h0080;
    localparam logic [MASK_W-1:0] B_MKREG  = 15'h0100;
    localparam logic [MASK_W-1:0] B_MKSOCK = 15'h0200;
    localparam logic [MASK_W-1:0] B_MKFIFO = 15'h0400;
    localparam logic [MASK_W-1:0] B_MKBLK  = 15'h0800;
    localparam logic [MASK_W-1:0] B_MKSYM  = 15'h1000;
    localparam logic [MASK_W-1:0] B_REFER  = 15'h2000;
    localparam logic [MASK_W-1:0] B_TRUNC  = 15'h4000;
    localparam logic [MASK_W-1:0] ALL_BITS = 15'h7FFF;

    localparam logic [MASK_W-1:0] FULL_C = B_MKCHR | B_MKDIR | B_MKREG | B_MKSOCK
                                         | B_MKFIFO | B_MKBLK | B_MKSYM;
    localparam logic [MASK_W-1:0] FULL_F = B_RFILE | B_WFILE | B_EXEC | B_TRUNC
                                         | B_RMFILE;
    localparam logic [MASK_W-1:0] FULL_D = B_RDIR | B_REFER | B_RMDIR | FULL_C;
    localparam logic [MASK_W-1:0] TOP_R  = B_RFILE | B_EXEC | B_RDIR;
    localparam logic [MASK_W-1:0] TOP_W  = B_WFILE | B_RMFILE | B_RMDIR | FULL_C;

    // Character codes.
    localparam logic [7:0] CH_UF    = "F";
    localparam logic [7:0] CH_UD    = "D";
    localparam logic [7:0] CH_UC    = "C";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_W     = "w";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_U     = "u";
    localparam logic [7:0] CH_M     = "m";
    localparam logic [7:0] CH_C     = "c";
    localparam logic [7:0] CH_D     = "d";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_L     = "l";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";

    // Item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [3:0]        phase;
        logic [MASK_W-1:0] mask;
        logic              unknown;
    } parse_state_t;

    typedef struct packed {
        logic              unknown_seen;
        logic              unclosed_group;
        logic [MASK_W-1:0] access_mask;
    } result_t;

endpackage

// ===== sv/arsp_step.sv =====
// ============================================================================
// arsp_step
// One parser step: next state and result for one character or end item.
// ============================================================================
module arsp_step (
    input  arsp_pkg::parse_state_t st,
    input  logic                   kind,
    input  logic [7:0]             char_code,
    output arsp_pkg::parse_state_t st_next,
    output arsp_pkg::result_t      res
);

    function automatic arsp_pkg::parse_state_t top_char(arsp_pkg::parse_state_t s,
                                                        logic [7:0] c);
        arsp_pkg::parse_state_t r;
        r = s;
        r.phase = arsp_pkg::PH_TOP;
        case (c) inside
            arsp_pkg::CH_UF:    r.phase = arsp_pkg::PH_FSEEN;
            arsp_pkg::CH_UD:    r.phase = arsp_pkg::PH_DSEEN;
            arsp_pkg::CH_R:     r.mask = r.mask | arsp_pkg::TOP_R;
            arsp_pkg::CH_W:     r.mask = r.mask | arsp_pkg::TOP_W;
            arsp_pkg::CH_STAR:  r.mask = arsp_pkg::ALL_BITS;
            arsp_pkg::CH_COMMA: r.unknown = s.unknown;
            default:            r.unknown = 1'b1;
        endcase
        return r;
    endfunction

    function automatic arsp_pkg::parse_state_t fgrp_char(arsp_pkg::parse_state_t s,
                                                         logic [7:0] c);
        arsp_pkg::parse_state_t r;
        r = s;
        r.phase = arsp_pkg::PH_FGRP;
        case (c) inside
            arsp_pkg::CH_CLOSE:                   r.phase = arsp_pkg::PH_TOP;
            arsp_pkg::CH_R:                       r.mask = r.mask | arsp_pkg::B_RFILE;
            arsp_pkg::CH_W:                       r.mask = r.mask | arsp_pkg::B_WFILE;
            arsp_pkg::CH_X:                       r.mask = r.mask | arsp_pkg::B_EXEC;
            arsp_pkg::CH_T:                       r.mask = r.mask | arsp_pkg::B_TRUNC;
            arsp_pkg::CH_U:                       r.mask = r.mask | arsp_pkg::B_RMFILE;
            arsp_pkg::CH_DASH, arsp_pkg::CH_COMMA: r.unknown = s.unknown;
            default:                              r.unknown = 1'b1;
        endcase
        return r;
    endfunction

    function automatic arsp_pkg::parse_state_t dgrp_char(arsp_pkg::parse_state_t s,
                                                         logic [7:0] c);
        arsp_pkg::parse_state_t r;
        r = s;
        r.phase = arsp_pkg::PH_DGRP;
        case (c) inside
            arsp_pkg::CH_CLOSE:                   r.phase = arsp_pkg::PH_TOP;
            arsp_pkg::CH_R:                       r.mask = r.mask | arsp_pkg::B_RDIR;
            arsp_pkg::CH_UC:                      r.phase = arsp_pkg::PH_CSEEN;
            arsp_pkg::CH_U:                       r.mask = r.mask | arsp_pkg::B_RMDIR;
            arsp_pkg::CH_M:                       r.mask = r.mask | arsp_pkg::B_REFER;
            arsp_pkg::CH_DASH, arsp_pkg::CH_COMMA: r.unknown = s.unknown;
            default:                              r.unknown = 1'b1;
        endcase
        return r;
    endfunction

    function automatic arsp_pkg::parse_state_t cgrp_char(arsp_pkg::parse_state_t s,
                                                         logic [7:0] c);
        arsp_pkg::parse_state_t r;
        r = s;
        r.phase = arsp_pkg::PH_CGRP;
        case (c) inside
            arsp_pkg::CH_CLOSE:              r.phase = arsp_pkg::PH_DGRP;
            arsp_pkg::CH_C:                  r.mask = r.mask | arsp_pkg::B_MKCHR;
            arsp_pkg::CH_D:                  r.mask = r.mask | arsp_pkg::B_MKDIR;
            arsp_pkg::CH_DASH, arsp_pkg::CH_R: r.mask = r.mask | arsp_pkg::B_MKREG;
            arsp_pkg::CH_S:                  r.mask = r.mask | arsp_pkg::B_MKSOCK;
            arsp_pkg::CH_F:                  r.mask = r.mask | arsp_pkg::B_MKFIFO;
            arsp_pkg::CH_B:                  r.mask = r.mask | arsp_pkg::B_MKBLK;
            arsp_pkg::CH_L:                  r.mask = r.mask | arsp_pkg::B_MKSYM;
            arsp_pkg::CH_COMMA:              r.unknown = s.unknown;
            default:                         r.unknown = 1'b1;
        endcase
        return r;
    endfunction

    arsp_pkg::parse_state_t chr_next;
    arsp_pkg::parse_state_t fin;
    arsp_pkg::parse_state_t s1;
    logic                   open_grp;

    // Character items: the letter after F, D or C is first checked as a
    // group opener, then handled at the enclosing level if it is not one.
    always_comb
    begin
        s1 = st;
        unique case (st.phase)
            arsp_pkg::PH_FSEEN:
            begin
                if (char_code == arsp_pkg::CH_OPEN)
                    chr_next = '{phase: arsp_pkg::PH_FOPEN, mask: st.mask,
                                 unknown: st.unknown};
                else
                begin
                    s1.mask = st.mask | arsp_pkg::FULL_F;
                    chr_next = top_char(s1, char_code);
                end
            end
            arsp_pkg::PH_FOPEN:
            begin
                if (char_code == arsp_pkg::CH_STAR)
                    chr_next = '{phase: arsp_pkg::PH_FSTAR, mask: st.mask,
                                 unknown: st.unknown};
                else
                    chr_next = fgrp_char(st, char_code);
            end
            arsp_pkg::PH_FSTAR:
            begin
                if (char_code == arsp_pkg::CH_CLOSE)
                    chr_next = '{phase: arsp_pkg::PH_TOP,
                                 mask: st.mask | arsp_pkg::FULL_F, unknown: st.unknown};
                else
                begin
                    s1.unknown = 1'b1;
                    chr_next = fgrp_char(s1, char_code);
                end
            end
            arsp_pkg::PH_FGRP:
                chr_next = fgrp_char(st, char_code);
            arsp_pkg::PH_DSEEN:
            begin
                if (char_code == arsp_pkg::CH_OPEN)
                    chr_next = '{phase: arsp_pkg::PH_DOPEN, mask: st.mask,
                                 unknown: st.unknown};
                else
                begin
                    s1.mask = st.mask | arsp_pkg::FULL_D;
                    chr_next = top_char(s1, char_code);
                end
            end
            arsp_pkg::PH_DOPEN:
            begin
                if (char_code == arsp_pkg::CH_STAR)
                    chr_next = '{phase: arsp_pkg::PH_DSTAR, mask: st.mask,
                                 unknown: st.unknown};
                else
                    chr_next = dgrp_char(st, char_code);
            end
            arsp_pkg::PH_DSTAR:
            begin
                if (char_code == arsp_pkg::CH_CLOSE)
                    chr_next = '{phase: arsp_pkg::PH_TOP,
                                 mask: st.mask | arsp_pkg::FULL_D, unknown: st.unknown};
                else
                begin
                    s1.unknown = 1'b1;
                    chr_next = dgrp_char(s1, char_code);
                end
            end
            arsp_pkg::PH_DGRP:
                chr_next = dgrp_char(st, char_code);
            arsp_pkg::PH_CSEEN:
            begin
                if (char_code == arsp_pkg::CH_OPEN)
                    chr_next = '{phase: arsp_pkg::PH_COPEN, mask: st.mask,
                                 unknown: st.unknown};
                else
                begin
                    s1.mask = st.mask | arsp_pkg::FULL_C;
                    chr_next = dgrp_char(s1, char_code);
                end
            end
            arsp_pkg::PH_COPEN:
            begin
                if (char_code == arsp_pkg::CH_STAR)
                    chr_next = '{phase: arsp_pkg::PH_CSTAR, mask: st.mask,
                                 unknown: st.unknown};
                else
                    chr_next = cgrp_char(st, char_code);
            end
            arsp_pkg::PH_CSTAR:
            begin
                if (char_code == arsp_pkg::CH_CLOSE)
                    chr_next = '{phase: arsp_pkg::PH_DGRP,
                                 mask: st.mask | arsp_pkg::FULL_C, unknown: st.unknown};
                else
                begin
                    s1.unknown = 1'b1;
                    chr_next = cgrp_char(s1, char_code);
                end
            end
            arsp_pkg::PH_CGRP:
                chr_next = cgrp_char(st, char_code);
            default:
                chr_next = top_char(st, char_code);
        endcase
    end

    // End items: settle a pending letter or "(*" and report.
    always_comb
    begin
        fin      = st;
        open_grp = 1'b0;
        unique case (st.phase)
            arsp_pkg::PH_FSEEN: fin.mask = st.mask | arsp_pkg::FULL_F;
            arsp_pkg::PH_DSEEN: fin.mask = st.mask | arsp_pkg::FULL_D;
            arsp_pkg::PH_CSEEN:
            begin
                fin.mask = st.mask | arsp_pkg::FULL_C;
                open_grp = 1'b1;
            end
            arsp_pkg::PH_FSTAR, arsp_pkg::PH_DSTAR, arsp_pkg::PH_CSTAR:
            begin
                fin.unknown = 1'b1;
                open_grp    = 1'b1;
            end
            arsp_pkg::PH_FOPEN, arsp_pkg::PH_FGRP, arsp_pkg::PH_DOPEN,
            arsp_pkg::PH_DGRP, arsp_pkg::PH_COPEN, arsp_pkg::PH_CGRP:
                open_grp = 1'b1;
            default:
                open_grp = 1'b0;
        endcase
    end

    always_comb
    begin
        res.access_mask    = fin.mask;
        res.unclosed_group = open_grp;
        res.unknown_seen   = fin.unknown;
        if (kind == arsp_pkg::KIND_END)
            st_next = '{phase: arsp_pkg::PH_TOP, mask: '0, unknown: 1'b0};
        else
            st_next = chr_next;
    end

endmodule

// ===== sv/arsp_out_buf.sv =====
// ============================================================================
// arsp_out_buf
// Two-entry result buffer: output register plus skid register.
// ============================================================================
module arsp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  arsp_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output arsp_pkg::result_t out_data
);

    logic              head_valid_reg;
    logic              head_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    arsp_pkg::result_t head_reg;
    arsp_pkg::result_t head_next;
    arsp_pkg::result_t skid_reg;
    arsp_pkg::result_t skid_next;
    logic              pop;

    assign pop = head_valid_reg && out_ready;

    // A push is only offered while the skid register is empty.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                head_next = push_data;
            else
                head_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

// ===== sv/access_rights_string_parser.sv =====
// ============================================================================
// access_rights_string_parser
// Streams an access-rights string in and returns its permission mask.
// ============================================================================
// Characters arrive one per beat on the slave side (tuser = 0) and an
// end-of-string beat (tuser = 1) closes the string. Each end beat yields one
// result beat holding the 15-bit mask, an unclosed-group flag and an
// unknown-character flag; the parser then returns to its reset state.
// Character beats produce no output. The block accepts one beat per cycle
// unless an end beat waits for buffer room: the parser state register is
// updated by a single short combinational step, so that state loop sets the
// rate. Two results may wait in the output buffer, and a third end beat in
// the input register, before the input side stalls.
module access_rights_string_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [14:0] access_mask, [15] unclosed_group,
                                        // [16] unknown_seen, [23:17] zero
);

    logic                   in_valid_reg;
    logic                   in_kind_reg;
    logic [7:0]             in_char_reg;
    logic                   step_go;
    logic                   buf_full;
    arsp_pkg::parse_state_t st_reg;
    arsp_pkg::parse_state_t st_next;
    arsp_pkg::result_t      res;
    arsp_pkg::result_t      out_res;

    // End beats need a free buffer entry; character beats always proceed.
    assign step_go = in_valid_reg && (in_kind_reg == arsp_pkg::KIND_CHAR || !buf_full);
    assign s_axis_tready = !in_valid_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= '{phase: arsp_pkg::PH_TOP, mask: '0, unknown: 1'b0};
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (step_go)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_kind_reg <= s_axis_tuser;
            in_char_reg <= s_axis_tdata;
        end
    end

    arsp_step u_step (
        .st        (st_reg),
        .kind      (in_kind_reg),
        .char_code (in_char_reg),
        .st_next   (st_next),
        .res       (res)
    );

    arsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_go && in_kind_reg == arsp_pkg::KIND_END),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {7'b0, out_res};

endmodule
